/* hdl/fcs16_pkg.sv */
`timescale 1ns / 1ps
// fcs16_pkg: shared types and constants of the frame checker
// no dependencies; used by every module of the block

package fcs16_pkg;

    localparam int unsigned MAX_DATA_DEFAULT = 256;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
    localparam logic [15:0] LEN_HI_MSK = 16'hFF00;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_LEN_OVER = 2'd2;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_CMD    = 8'b0000_0010,
        PH_LEN_LO = 8'b0000_0100,
        PH_LEN_HI = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_CK_HI  = 8'b0010_0000,
        PH_CK_LO  = 8'b0100_0000,
        PH_STOP   = 8'b1000_0000
    } phase_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [1:0]  status;
    } result_t;

    // queue status: full gates s_ready at the top level, avail is seen by the back
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

/* hdl/fcs16_front.sv */
`timescale 1ns / 1ps
// fcs16_front: frame parser, running sum and start byte register
// depends on fcs16_pkg

module fcs16_front #(
    parameter int unsigned MAX_DATA = fcs16_pkg::MAX_DATA_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output fcs16_pkg::result_t  push_item
);

    localparam int unsigned CNT_W = (MAX_DATA < 2) ? 1 : $clog2(MAX_DATA + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_DATA);

    fcs16_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        start_reg;
    logic [7:0]        cmd_reg, cmd_next;
    logic [15:0]       len_reg, len_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        ckhi_reg, ckhi_next;
    logic [15:0]       sum_plus_byte;
    logic [15:0]       len_full;

    assign sum_plus_byte = sum_reg + {8'h00, rx_byte};
    assign len_full      = (len_reg & ~fcs16_pkg::LEN_HI_MSK) | {rx_byte, 8'h00};

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        ckhi_next  = ckhi_reg;
        push       = 1'b0;
        push_item  = '{kind: fcs16_pkg::KIND_DATA, data_byte: 8'h00, command: cmd_reg,
                       frame_length: len_reg, status: fcs16_pkg::STATUS_OK};
        if (take) begin
            unique case (phase_reg)
                fcs16_pkg::PH_CMD: begin
                    cmd_next   = rx_byte;
                    sum_next   = {8'h00, rx_byte};
                    phase_next = fcs16_pkg::PH_LEN_LO;
                end
                fcs16_pkg::PH_LEN_LO: begin
                    len_next   = {8'h00, rx_byte};
                    sum_next   = sum_plus_byte;
                    phase_next = fcs16_pkg::PH_LEN_HI;
                end
                fcs16_pkg::PH_LEN_HI: begin
                    len_next = len_full;
                    sum_next = sum_plus_byte;
                    if (len_full > MAX_LEN) begin
                        push                   = 1'b1;
                        push_item.kind         = fcs16_pkg::KIND_REPORT;
                        push_item.frame_length = len_full;
                        push_item.status       = fcs16_pkg::STATUS_LEN_OVER;
                        phase_next             = fcs16_pkg::PH_HUNT;
                    end else begin
                        left_next  = len_full[CNT_W-1:0];
                        phase_next = (len_full == 16'h0000) ? fcs16_pkg::PH_CK_HI
                                                            : fcs16_pkg::PH_DATA;
                    end
                end
                fcs16_pkg::PH_DATA: begin
                    sum_next  = sum_plus_byte;
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1)) begin
                        phase_next = fcs16_pkg::PH_CK_HI;
                    end
                    push                = 1'b1;
                    push_item.data_byte = rx_byte;
                end
                fcs16_pkg::PH_CK_HI: begin
                    ckhi_next  = rx_byte;
                    phase_next = fcs16_pkg::PH_CK_LO;
                end
                fcs16_pkg::PH_CK_LO: begin
                    sum_next   = sum_reg + {ckhi_reg, rx_byte};
                    phase_next = fcs16_pkg::PH_STOP;
                end
                fcs16_pkg::PH_STOP: begin
                    push             = 1'b1;
                    push_item.kind   = fcs16_pkg::KIND_REPORT;
                    push_item.status = (sum_reg == fcs16_pkg::SUM_GOOD)
                                       ? fcs16_pkg::STATUS_OK : fcs16_pkg::STATUS_BAD_SUM;
                    phase_next       = fcs16_pkg::PH_HUNT;
                end
                default: begin
                    if (rx_byte == start_reg) begin
                        sum_next   = 16'h0000;
                        phase_next = fcs16_pkg::PH_CMD;
                    end else begin
                        phase_next = fcs16_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fcs16_pkg::PH_HUNT;
            start_reg <= 8'h00;
            cmd_reg   <= 8'h00;
            len_reg   <= 16'h0000;
            left_reg  <= '0;
            sum_reg   <= 16'h0000;
            ckhi_reg  <= 8'h00;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            ckhi_reg  <= ckhi_next;
            if (cfg_we) begin
                start_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* hdl/fcs16_queue.sv */
`timescale 1ns / 1ps
// fcs16_queue: short fifo of result items between parser and output stage
// depends on fcs16_pkg

module fcs16_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fcs16_pkg::result_t    push_item,
    input  logic                  pop,
    output fcs16_pkg::result_t    head_item,
    output fcs16_pkg::q_status_t  stat
);

    localparam int unsigned DEPTH = fcs16_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fcs16_pkg::result_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.avail = (count_reg != '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.avail;
    assign head_item  = mem[rd_ptr_reg];

    // pointer wrap at depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/fcs16_back.sv */
`timescale 1ns / 1ps
// fcs16_back: output register stage driving the result channel
// depends on fcs16_pkg

module fcs16_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fcs16_pkg::q_status_t  stat,
    input  fcs16_pkg::result_t    head_item,
    output logic                  pop,
    input  logic                  out_ready,
    output logic                  out_valid,
    output fcs16_pkg::result_t    out_item
);

    logic               valid_reg;
    fcs16_pkg::result_t item_reg;

    assign pop       = stat.avail && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

/* hdl/frame_checker_sum16_unit.sv */
`timescale 1ns / 1ps
// frame_checker_sum16_unit: receive-side checker for length-prefixed byte frames
// path: an item is queued when its byte is accepted, then moved to the output register when it frees
// throughput: one byte per cycle; s_ready drops only when the 2-entry queue is full
// reset: synchronous active-low aresetn clears parser phase, sum, queue and output valid
// depends on fcs16_pkg, fcs16_front, fcs16_queue, fcs16_back

module frame_checker_sum16_unit #(
    parameter int unsigned MAX_DATA = fcs16_pkg::MAX_DATA_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // start byte register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // received bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // data bytes and end of frame reports
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_command,
    output logic [15:0] m_frame_length,
    output logic [1:0]  m_status
);

    logic                 take;
    logic                 push;
    logic                 pop;
    fcs16_pkg::result_t   push_item;
    fcs16_pkg::result_t   head_item;
    fcs16_pkg::result_t   out_item;
    fcs16_pkg::q_status_t q_stat;

    // accept a byte whenever the queue has room; the parser never stalls itself
    assign s_ready = !q_stat.full;
    assign take    = s_valid && s_ready;

    // front: phase tracking, running sum, item generation
    fcs16_front #(
        .MAX_DATA (MAX_DATA)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .rx_byte   (s_rx_byte),
        .push      (push),
        .push_item (push_item)
    );

    // short queue decouples parser from downstream backpressure
    fcs16_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // back: registered result channel
    fcs16_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stat      (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_item  (out_item)
    );

    // unpack the result item onto its ports
    assign m_kind         = out_item.kind;
    assign m_data_byte    = out_item.data_byte;
    assign m_command      = out_item.command;
    assign m_frame_length = out_item.frame_length;
    assign m_status       = out_item.status;

endmodule

/* hdl/fcs16_checker.sv */
`timescale 1ns / 1ps
// fcs16_checker: port-level assertions on the result channel
// depends on fcs16_pkg; bound to frame_checker_sum16_unit

module fcs16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [7:0]  m_data_byte,
    input logic [7:0]  m_command,
    input logic [15:0] m_frame_length,
    input logic [1:0]  m_status
);

    // no result survives a reset cycle
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte)
            && $stable(m_command) && $stable(m_frame_length) && $stable(m_status))
        else $error("stalled item changed");

    // data items carry ok status
    a_data_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == fcs16_pkg::KIND_DATA |-> m_status == fcs16_pkg::STATUS_OK)
        else $error("data item with non-ok status");

    // reports carry a zero data byte and a legal status
    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == fcs16_pkg::KIND_REPORT |->
            m_data_byte == 8'h00 && m_status != 2'd3)
        else $error("malformed report");

endmodule

bind frame_checker_sum16_unit fcs16_checker u_fcs16_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_data_byte    (m_data_byte),
    .m_command      (m_command),
    .m_frame_length (m_frame_length),
    .m_status       (m_status)
);
